// File: rtl/bits_pkg.sv
// ----------------------------------------------------------------------------
// bits_pkg: shared definitions for the beam-interleaved trigger scheduler.
// Field widths, configuration register indexes and the fixed time-base
// constants used by the scheduler.
// ----------------------------------------------------------------------------
package bits_pkg;

  // Longest firing sequence supported.
  localparam int SEQ_MAX = 16;

  // Field widths.
  localparam int TIME_W    = 48;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int IDX_W     = 4;
  localparam int REP_W     = 8;
  localparam int LEN_W     = 5;
  localparam int PRE_W     = 16;
  localparam int PREC_W    = 23;   // prewarn in coarse counts
  localparam int DUS_W     = 28;   // beam delay in microseconds
  localparam int DCNT_W    = 35;   // beam delay in coarse counts
  localparam int THR_W     = 30;   // signed spill wait threshold
  localparam int PUS_W     = 26;   // period in microseconds

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPILL_MOD  = 3'd0,
    REG_BEAM_DELAY = 3'd1,
    REG_PREWARN    = 3'd2,
    REG_PERIOD     = 3'd3,
    REG_EXTRA_REPS = 3'd4,
    REG_SEQ_LEN    = 3'd5,
    REG_ADVANCE    = 3'd6,
    REG_OFFSET     = 3'd7
  } cfg_reg_t;

  // Time base: 125 coarse counts per microsecond.
  localparam logic [PREC_W-1:0] COUNTS_PER_US = 23'd125;
  localparam logic [DUS_W-1:0]  US_PER_S      = 28'd1000000;
  localparam logic [DCNT_W-1:0] COUNTS_PER_S  = 35'd125000000;

  // Division of a 32-bit count by 125 as a reciprocal multiply and shift.
  localparam logic [CFG_W-1:0] DIV125_MULT  = 32'd2199023256;
  localparam int               DIV125_SHIFT = 38;

  // Configuration reset values.
  localparam logic [PRE_W-1:0]  PREWARN_RST = 16'd20;
  localparam logic [CFG_W-1:0]  PERIOD_RST  = 32'd125;
  localparam logic [LEN_W-1:0]  SEQ_LEN_RST = 5'd1;

endpackage

// File: rtl/beam_interleaved_trigger_scheduler_top.sv
// ----------------------------------------------------------------------------
// beam_interleaved_trigger_scheduler_top: beam-interleaved trigger scheduler.
// A beat is registered on entry; its alert, if any, is registered in the
// output register once that register can take it. Throughput: one beat per
// cycle while out_ready does not stall the output; each beat's state update
// is a single pass of 48-bit adds and compares between the input and output
// registers. Reset clears scheduler state and valid flags, loads cfg defaults.
// ----------------------------------------------------------------------------
module beam_interleaved_trigger_scheduler_top (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port
  input  logic                          cfg_we,
  input  logic [bits_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bits_pkg::CFG_W-1:0]    cfg_data,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          run_enable,
  input  logic [bits_pkg::TIME_W-1:0]   now_us,
  input  logic [bits_pkg::TIME_W-1:0]   coarse_count,
  input  logic                          beam_on,
  input  logic                          link_ready,
  // Output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bits_pkg::IDX_W-1:0]    entry_index,
  output logic [bits_pkg::REP_W-1:0]    repetition,
  output logic [bits_pkg::TIME_W-1:0]   start_count
);
  import bits_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers and derived constants
  // --------------------------------------------------------------------------
  logic [7:0]        spill_every;
  logic [PRE_W-1:0]  prewarn_us;
  logic [CFG_W-1:0]  period_counts;
  logic [7:0]        extra_repeats;
  logic [LEN_W-1:0]  sequence_length;
  logic [CFG_W-1:0]  advance_counts;
  logic [CFG_W-1:0]  counter_offset;
  logic [PREC_W-1:0] prewarn_counts;
  logic [DUS_W-1:0]  delay_us;
  logic [DCNT_W-1:0] delay_counts;
  logic [THR_W-1:0]  spill_thr;
  logic [PUS_W-1:0]  period_us;
  logic [TIME_W-1:0] seed_bias;
  logic [TIME_W-1:0] beam_bias;

  logic [DUS_W-1:0]  wr_delay_us;
  logic [DCNT_W-1:0] wr_delay_counts;
  logic [PREC_W-1:0] wr_prewarn_counts;
  logic [63:0]       wr_period_prod;
  logic [TIME_W-1:0] ofs_ext;
  logic [TIME_W-1:0] wr_ofs_ext;

  // Values derived from the write data, so they are ready with the register; ofs_ext extends the stored offset.
  always_comb begin
    wr_delay_us       = DUS_W'(cfg_data[7:0]) * US_PER_S;
    wr_delay_counts   = DCNT_W'(cfg_data[7:0]) * COUNTS_PER_S;
    wr_prewarn_counts = PREC_W'(cfg_data[PRE_W-1:0]) * COUNTS_PER_US;
    wr_period_prod    = 64'(cfg_data) * 64'(DIV125_MULT);
    ofs_ext           = {{(TIME_W-CFG_W){counter_offset[CFG_W-1]}}, counter_offset};
    wr_ofs_ext        = {{(TIME_W-CFG_W){cfg_data[CFG_W-1]}}, cfg_data};
  end

  // Register writes; each write also refreshes the constants that depend on it.
  always_ff @(posedge clk) begin
    if (rst) begin
      spill_every     <= '0;
      prewarn_us      <= PREWARN_RST;
      period_counts   <= PERIOD_RST;
      extra_repeats   <= '0;
      sequence_length <= SEQ_LEN_RST;
      advance_counts  <= '0;
      counter_offset  <= '0;
      prewarn_counts  <= PREC_W'(PREWARN_RST) * COUNTS_PER_US;
      delay_us        <= '0;
      delay_counts    <= '0;
      spill_thr       <= THR_W'(0) - THR_W'(PREWARN_RST);
      period_us       <= PUS_W'(1);
      seed_bias       <= TIME_W'(PREC_W'(PREWARN_RST) * COUNTS_PER_US);
      beam_bias       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SPILL_MOD: begin
          spill_every <= cfg_data[7:0];
        end
        REG_BEAM_DELAY: begin
          delay_us     <= wr_delay_us;
          delay_counts <= wr_delay_counts;
          spill_thr    <= THR_W'(wr_delay_us) - THR_W'(prewarn_us);
          beam_bias    <= TIME_W'(wr_delay_counts) - TIME_W'(advance_counts);
        end
        REG_PREWARN: begin
          prewarn_us     <= cfg_data[PRE_W-1:0];
          prewarn_counts <= wr_prewarn_counts;
          spill_thr      <= THR_W'(delay_us) - THR_W'(cfg_data[PRE_W-1:0]);
          seed_bias      <= TIME_W'(wr_prewarn_counts) - TIME_W'(advance_counts) + ofs_ext;
        end
        REG_PERIOD: begin
          period_counts <= cfg_data;
          period_us     <= wr_period_prod[DIV125_SHIFT +: PUS_W];
        end
        REG_EXTRA_REPS: begin
          extra_repeats <= cfg_data[7:0];
        end
        REG_SEQ_LEN: begin
          sequence_length <= cfg_data[LEN_W-1:0];
        end
        REG_ADVANCE: begin
          advance_counts <= cfg_data;
          seed_bias      <= TIME_W'(prewarn_counts) - TIME_W'(cfg_data) + ofs_ext;
          beam_bias      <= TIME_W'(delay_counts) - TIME_W'(cfg_data);
        end
        REG_OFFSET: begin
          counter_offset <= cfg_data;
          seed_bias      <= TIME_W'(prewarn_counts) - TIME_W'(advance_counts) + wr_ofs_ext;
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register and handshake
  // --------------------------------------------------------------------------
  logic              in_full;
  logic              run_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] coarse_q;
  logic              beam_q;
  logic              link_q;
  logic              proc;

  // A held beat is processed once the output register can take its result.
  assign proc     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      run_q    <= run_enable;
      now_q    <= now_us;
      coarse_q <= coarse_count;
      beam_q   <= beam_on;
      link_q   <= link_ready;
    end
  end

  // --------------------------------------------------------------------------
  // Scheduler state
  // --------------------------------------------------------------------------
  logic              was_enabled;
  logic [IDX_W-1:0]  seq_index;
  logic [REP_W-1:0]  reps_done;
  logic              prev_beam;
  logic [TIME_W-1:0] spill_end_us;
  logic [TIME_W-1:0] spill_end_count;
  logic [7:0]        spills_seen;
  logic [TIME_W-1:0] last_alert_us;
  logic [TIME_W-1:0] last_start_count;

  // --------------------------------------------------------------------------
  // Decision logic for the held beat
  // --------------------------------------------------------------------------
  logic              seed;
  logic              beam_mode;
  logic [IDX_W-1:0]  seq_eff;
  logic [REP_W-1:0]  reps_eff;
  logic              prev_eff;
  logic [7:0]        spills_base;
  logic [7:0]        spills_eff;
  logic              fall;
  logic              spill_now;
  logic [TIME_W-1:0] lapse_spill;
  logic [TIME_W-1:0] lapse_alert;
  logic [TIME_W-1:0] thr_ext;
  logic              spill_ok;
  logic              period_ok;
  logic              fire;
  logic [TIME_W-1:0] last_start_seed;
  logic [TIME_W-1:0] last_start_eff;
  logic [TIME_W-1:0] start_next;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  nidx;
  logic [REP_W:0]    nreps;
  logic [REP_W:0]    rep_limit;
  logic              seq_wrap;
  logic              run_wrap;
  logic [IDX_W-1:0]  seq_index_next;
  logic [REP_W-1:0]  reps_done_next;

  always_comb begin
    // A newly enabled run starts from freshly seeded state.
    seed        = !was_enabled;
    beam_mode   = (spill_every != 8'd0);
    seq_eff     = seed ? '0 : seq_index;
    reps_eff    = seed ? '0 : reps_done;
    prev_eff    = seed ? 1'b0 : prev_beam;
    spills_base = seed ? 8'd0 : spills_seen;

    // Spill end on a falling edge of the beam flag.
    fall       = beam_mode && prev_eff && !beam_q;
    spill_now  = seed || fall;
    spills_eff = (fall && (spills_base != 8'hFF)) ? spills_base + 8'd1 : spills_base;

    // Elapsed times as signed 48-bit differences.
    lapse_spill = spill_now ? '0 : now_q - spill_end_us;
    lapse_alert = seed ? TIME_W'(prewarn_us) : now_q - last_alert_us;
    thr_ext     = {{(TIME_W-THR_W){spill_thr[THR_W-1]}}, spill_thr};

    spill_ok  = !beam_mode ||
                ((spills_eff >= spill_every) && !($signed(lapse_spill) < $signed(thr_ext)));
    period_ok = !($signed(lapse_alert) < $signed(TIME_W'(period_us)));
    fire      = run_q && spill_ok && period_ok && link_q;

    // Start count: from the spill end for the first entry in beam mode,
    // otherwise one period after the previous start.
    last_start_seed = coarse_q + seed_bias;
    last_start_eff  = seed ? last_start_seed : last_start_count;
    if (beam_mode && (seq_eff == '0)) begin
      start_next = (spill_now ? coarse_q : spill_end_count) + beam_bias;
    end else begin
      start_next = last_start_eff + TIME_W'(period_counts);
    end

    // Sequence and repetition advance.
    if (sequence_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (sequence_length > LEN_W'(SEQ_MAX)) begin
      len_eff = LEN_W'(SEQ_MAX);
    end else begin
      len_eff = sequence_length;
    end
    nidx      = LEN_W'(seq_eff) + LEN_W'(1);
    seq_wrap  = (nidx >= len_eff);
    nreps     = seq_wrap ? {1'b0, reps_eff} + (REP_W+1)'(1) : {1'b0, reps_eff};
    rep_limit = {1'b0, extra_repeats} + (REP_W+1)'(1);
    run_wrap  = (nreps >= rep_limit);
    if (run_wrap) begin
      seq_index_next = '0;
      reps_done_next = '0;
    end else begin
      seq_index_next = seq_wrap ? '0 : nidx[IDX_W-1:0];
      reps_done_next = nreps[REP_W-1:0];
    end
  end

  // State update for each processed beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      was_enabled      <= 1'b0;
      seq_index        <= '0;
      reps_done        <= '0;
      prev_beam        <= 1'b0;
      spill_end_us     <= '0;
      spill_end_count  <= '0;
      spills_seen      <= '0;
      last_alert_us    <= '0;
      last_start_count <= '0;
    end else if (proc) begin
      if (!run_q) begin
        was_enabled <= 1'b0;
      end else begin
        was_enabled <= 1'b1;
        seq_index   <= fire ? seq_index_next : seq_eff;
        reps_done   <= fire ? reps_done_next : reps_eff;
        prev_beam   <= beam_mode ? beam_q : prev_eff;
        if (spill_now) begin
          spill_end_us    <= now_q;
          spill_end_count <= coarse_q;
        end
        spills_seen <= (fire && run_wrap) ? 8'd0 : spills_eff;
        if (fire) begin
          last_alert_us    <= now_q;
          last_start_count <= start_next;
        end else if (seed) begin
          last_alert_us    <= now_q - TIME_W'(prewarn_us);
          last_start_count <= last_start_seed;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= fire;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && fire) begin
      entry_index <= seq_eff;
      repetition  <= reps_eff;
      start_count <= start_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // An alert records its own time as the last alert time.
  a_alert_time: assert property (@(posedge clk) disable iff (rst)
    (proc && fire) |=> (last_alert_us == $past(now_q)))
    else $error("last alert time not updated by an alert");

  // An alert always reaches the output register.
  a_alert_out: assert property (@(posedge clk) disable iff (rst)
    (proc && fire) |=> (out_valid && (start_count == $past(start_next))))
    else $error("alert lost on its way to the output register");

  // The spill count only grows, or is cleared.
  a_spills_mono: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> ((spills_seen >= $past(spills_seen)) || (spills_seen == 8'd0)))
    else $error("spill count went backwards");

  // Reset empties both the input and the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!in_full && !out_valid))
    else $error("registers not empty after reset");
`endif

endmodule
